// File: hdl/mptk_pkg.sv
// Shared types, constants and helper functions for the PS/2 mouse packet tracker.
`default_nettype none

package mptk_pkg;

    localparam int MAX_SCREEN  = 8192;
    localparam int SIZE_W      = 14;
    localparam int COORD_W     = 13;
    localparam int BTN_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYNC_MASK     = 8'h08;
    localparam logic [7:0] OVERFLOW_MASK = 8'hC0;
    localparam logic [7:0] BUTTON_MASK   = 8'h07;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0]  RESET_WIDTH    = 14'd1024;
    localparam logic [SIZE_W-1:0]  RESET_HEIGHT   = 14'd768;
    localparam logic [COORD_W-1:0] RESET_CURSOR_X = 13'd512;
    localparam logic [COORD_W-1:0] RESET_CURSOR_Y = 13'd384;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       clear_moved;
    } t_in_beat;

    typedef struct packed {
        logic               packet_done;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [BTN_W-1:0]   button_bits;
        logic               moved_flag;
    } t_out_beat;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic             apply;
        logic [BTN_W-1:0] buttons;
        logic [7:0]       dx;
        logic [7:0]       dy;
        logic             clear_moved;
    } t_cmd;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SCREEN)) begin
            r = SIZE_W'(MAX_SCREEN);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [SIZE_W:0] v,
                                                       input logic [SIZE_W-1:0] size);
        logic [COORD_W-1:0] r;
        if (v[SIZE_W]) begin
            r = '0;
        end else if (v[SIZE_W-1:0] >= size) begin
            r = COORD_W'(size - SIZE_W'(1));
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mptk_front.sv
// Front end: assembles mouse bytes into packets and issues one command per beat.
`default_nettype none

module mptk_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_full,
    input  wire mptk_pkg::t_in_beat i_beat,
    output logic                  o_push,
    output mptk_pkg::t_cmd        o_cmd
);
    import mptk_pkg::*;

    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_DX     = 2'd1;
    localparam logic [1:0] POS_DY     = 2'd2;

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_dx, n_dx;

    assign o_push = i_valid && !i_full;

    always_comb begin
        n_pos             = r_pos;
        n_hdr             = r_hdr;
        n_dx              = r_dx;
        o_cmd.apply       = 1'b0;
        o_cmd.buttons     = BTN_W'(r_hdr & BUTTON_MASK);
        o_cmd.dx          = r_dx;
        o_cmd.dy          = i_beat.data_byte;
        o_cmd.clear_moved = i_beat.clear_moved;
        case (r_pos)
            POS_HEADER: begin
                if ((i_beat.data_byte & SYNC_MASK) != 8'h00) begin
                    n_hdr = i_beat.data_byte;
                    n_pos = POS_DX;
                end
            end
            POS_DX: begin
                n_dx  = i_beat.data_byte;
                n_pos = POS_DY;
            end
            default: begin
                n_pos       = POS_HEADER;
                o_cmd.apply = (r_hdr & OVERFLOW_MASK) == 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HEADER;
            r_hdr <= 8'h00;
            r_dx  <= 8'h00;
        end else if (o_push) begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
            r_dx  <= n_dx;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mptk_queue.sv
// Short command queue between the packet front end and the cursor back end.
`default_nettype none

module mptk_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mptk_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output mptk_pkg::t_cmd     o_cmd
);
    import mptk_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [QUEUE_AW-1:0] bump(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] r;
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + QUEUE_AW'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: hdl/mptk_back.sv
// Back end: applies packets to the cursor, holds the screen size and the output register.
`default_nettype none

module mptk_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mptk_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_empty,
    input  wire mptk_pkg::t_cmd    i_cmd,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output mptk_pkg::t_out_beat    o_beat
);
    import mptk_pkg::*;

    logic [SIZE_W-1:0]  r_eff_w, r_eff_h;
    logic [COORD_W-1:0] r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic [BTN_W-1:0]   r_btn, n_btn;
    logic               r_moved, n_moved;
    logic               r_out_valid;
    t_out_beat          r_out;
    logic [SIZE_W:0]    sum_x, sum_y;
    logic [COORD_W-1:0] clamp_x, clamp_y;
    logic               moved_base;

    assign o_pop   = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

    assign sum_x   = (SIZE_W + 1)'({2'b00, r_cur_x})
                   + (SIZE_W + 1)'({{(SIZE_W - 7){i_cmd.dx[7]}}, i_cmd.dx});
    assign sum_y   = (SIZE_W + 1)'({2'b00, r_cur_y})
                   - (SIZE_W + 1)'({{(SIZE_W - 7){i_cmd.dy[7]}}, i_cmd.dy});
    assign clamp_x = clamp_coord(sum_x, r_eff_w);
    assign clamp_y = clamp_coord(sum_y, r_eff_h);

    always_comb begin
        moved_base = i_cmd.clear_moved ? 1'b0 : r_moved;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_btn      = r_btn;
        n_moved    = moved_base;
        if (i_cmd.apply) begin
            n_cur_x = clamp_x;
            n_cur_y = clamp_y;
            n_btn   = i_cmd.buttons;
            n_moved = moved_base || (clamp_x != r_cur_x) || (clamp_y != r_cur_y)
                      || (i_cmd.buttons != r_btn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= RESET_WIDTH;
            r_eff_h <= RESET_HEIGHT;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_SCREEN_WIDTH:  r_eff_w <= eff_size(i_cfg.data);
                CFG_SCREEN_HEIGHT: r_eff_h <= eff_size(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= RESET_CURSOR_X;
            r_cur_y     <= RESET_CURSOR_Y;
            r_btn       <= '0;
            r_moved     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_x     <= n_cur_x;
                r_cur_y     <= n_cur_y;
                r_btn       <= n_btn;
                r_moved     <= n_moved;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.packet_done <= i_cmd.apply;
            r_out.pos_x       <= n_cur_x;
            r_out.pos_y       <= n_cur_y;
            r_out.button_bits <= n_btn;
            r_out.moved_flag  <= n_moved;
        end
    end

`ifndef SYNTHESIS
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eff_w != '0 && r_eff_h != '0
        && r_eff_w <= SIZE_W'(MAX_SCREEN) && r_eff_h <= SIZE_W'(MAX_SCREEN))
        else $error("effective screen size out of range");
    a_hold_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_cmd.apply) |=> (r_cur_x == $past(r_cur_x)
                                     && r_cur_y == $past(r_cur_y)
                                     && r_btn == $past(r_btn)))
        else $error("cursor changed without a completed packet");
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_pop) |-> (r_out.pos_x == r_cur_x && r_out.pos_y == r_cur_y
                          && r_out.moved_flag == r_moved))
        else $error("result beat disagrees with cursor state");
`endif

endmodule

`default_nettype wire

// File: hdl/ps2_mouse_packet_tracker_top.sv
// Top level of the PS/2 mouse packet tracker: front end, command queue and back end.
// An accepted input beat goes into the command queue, then the back end's output register.
// Throughput: one input beat and one result beat per cycle when the output is not stalled.
// The two-entry command queue absorbs output stalls; input stalls once it is full.
// Reset is synchronous, active low: screen 1024 x 768, cursor (512, 384), buttons and
// the moved flag cleared, packet assembly waiting for a header byte, queue empty.
`default_nettype none

module ps2_mouse_packet_tracker_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire mptk_pkg::t_in_beat                i_in_beat,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output mptk_pkg::t_out_beat                    o_out_beat,
    input  wire logic                              i_cfg_we,
    input  wire logic [mptk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mptk_pkg::SIZE_W-1:0]       i_cfg_data
);
    import mptk_pkg::*;

    logic    push, pop, full, empty;
    t_cmd    front_cmd, queue_cmd;
    t_cfg_wr cfg;

    assign o_in_stall = full;
    assign cfg.we     = i_cfg_we;
    assign cfg.index  = i_cfg_index;
    assign cfg.data   = i_cfg_data;

    mptk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_full  (full),
        .i_beat  (i_in_beat),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    mptk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    mptk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat)
    );

endmodule

`default_nettype wire

// File: verif/tb_ps2_mouse_packet_tracker_top.sv
// Self-checking testbench for the PS/2 mouse packet tracker: directed table, then random packets.
module tb_ps2_mouse_packet_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mptk_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [1:0] SLOT_HEADER = 2'd0;
    localparam logic [1:0] SLOT_DX     = 2'd1;
    localparam logic [1:0] SLOT_DY     = 2'd2;

    localparam int STALL_FREE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    localparam int NUM_PHASES   = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [7:0]         data;
        logic               clr;
        logic               typed;
        logic               done;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   btn;
        logic               mv;
    } t_dir_row;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_beat             in_beat;
    logic                 out_valid;
    logic                 out_stall;
    t_out_beat            out_beat;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    logic [1:0]         pkt_slot;
    logic [7:0]         pkt_header;
    logic [7:0]         pkt_dx;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [BTN_W-1:0]   cur_btn;
    logic               cur_moved;
    logic [SIZE_W-1:0]  scr_w;
    logic [SIZE_W-1:0]  scr_h;

    t_out_beat track_q[$];
    t_in_beat  stim_q[$];
    int        err_count  = 0;
    int        burst_left = 0;
    bit        hold_req   = 1'b0;

    t_dir_row directed_rows [0:25] = '{
        '{8'h00, 1'b1, 1'b1, 1'b0, 13'd512, 13'd384, 3'd0, 1'b0},
        '{8'hF7, 1'b0, 1'b1, 1'b0, 13'd512, 13'd384, 3'd0, 1'b0},
        '{8'h0F, 1'b0, 1'b1, 1'b0, 13'd512, 13'd384, 3'd0, 1'b0},
        '{8'h7F, 1'b0, 1'b1, 1'b0, 13'd512, 13'd384, 3'd0, 1'b0},
        '{8'h80, 1'b0, 1'b1, 1'b1, 13'd639, 13'd512, 3'd7, 1'b1},
        '{8'hC8, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b1},
        '{8'h55, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b1},
        '{8'hAA, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b1},
        '{8'h48, 1'b1, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'h01, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'h01, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'h88, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'h08, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd7, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 13'd639, 13'd512, 3'd0, 1'b1},
        '{8'h09, 1'b1, 1'b1, 1'b0, 13'd639, 13'd512, 3'd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 13'd639, 13'd512, 3'd1, 1'b1},
        '{8'h09, 1'b1, 1'b1, 1'b0, 13'd639, 13'd512, 3'd1, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 13'd639, 13'd512, 3'd1, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 13'd639, 13'd512, 3'd1, 1'b0},
        '{8'h0C, 1'b0, 1'b0, 1'b0, 13'd0,   13'd0,   3'd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 13'd0,   13'd0,   3'd0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 13'd0,   13'd0,   3'd0, 1'b0}
    };

    ps2_mouse_packet_tracker_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic [COORD_W-1:0] fit_coord(input int pos,
                                                     input logic [SIZE_W-1:0] reg_val);
        int lim;
        if (reg_val == '0) begin
            lim = 1;
        end else if (int'(reg_val) > MAX_SCREEN) begin
            lim = MAX_SCREEN;
        end else begin
            lim = int'(reg_val);
        end
        if (pos < 0) pos = 0;
        if (pos >= lim) pos = lim - 1;
        return pos[COORD_W-1:0];
    endfunction

    function automatic t_out_beat track_byte(input t_in_beat b);
        t_out_beat          r;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [BTN_W-1:0]   nb;
        r = '0;
        if (b.clear_moved) cur_moved = 1'b0;
        case (pkt_slot)
            SLOT_HEADER: begin
                if ((b.data_byte & SYNC_MASK) != '0) begin
                    pkt_header = b.data_byte;
                    pkt_slot   = SLOT_DX;
                end
            end
            SLOT_DX: begin
                pkt_dx   = b.data_byte;
                pkt_slot = SLOT_DY;
            end
            default: begin
                pkt_slot = SLOT_HEADER;
                if ((pkt_header & OVERFLOW_MASK) == '0) begin
                    nb = pkt_header[BTN_W-1:0];
                    nx = fit_coord(int'(cur_x) + int'($signed(pkt_dx)), scr_w);
                    ny = fit_coord(int'(cur_y) - int'($signed(b.data_byte)), scr_h);
                    if (nx != cur_x || ny != cur_y || nb != cur_btn) cur_moved = 1'b1;
                    cur_x         = nx;
                    cur_y         = ny;
                    cur_btn       = nb;
                    r.packet_done = 1'b1;
                end
            end
        endcase
        r.pos_x       = cur_x;
        r.pos_y       = cur_y;
        r.button_bits = cur_btn;
        r.moved_flag  = cur_moved;
        return r;
    endfunction

    function automatic t_in_beat beat_of(input logic [7:0] data, input logic clr);
        t_in_beat b;
        b.data_byte   = data;
        b.clear_moved = clr;
        return b;
    endfunction

    function automatic logic [7:0] pick_delta(input logic [7:0] extreme, input int drift);
        return ($urandom_range(0, 7) < drift) ? extreme : 8'($urandom);
    endfunction

    // The sender works in bursts; a typed row overrides the predicted beat.
    task automatic offer(input t_in_beat b, input logic typed, input t_out_beat want);
        t_out_beat predicted;
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = track_byte(b);
        track_q.push_back(typed ? want : predicted);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_SCREEN_WIDTH) begin
            scr_w = val;
        end else if (idx == CFG_SCREEN_HEIGHT) begin
            scr_h = val;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (track_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed packets, with stray bytes that can knock the framing off.
    task automatic build_phase(input int n_bytes, input int drift);
        logic [7:0] x_ext;
        logic [7:0] y_ext;
        logic [7:0] hdr;
        x_ext = ($urandom_range(0, 1) == 1) ? 8'h7F : 8'h80;
        y_ext = ($urandom_range(0, 1) == 1) ? 8'h7F : 8'h80;
        while (stim_q.size() < n_bytes) begin
            if ($urandom_range(0, 7) == 0) begin
                stim_q.push_back(beat_of(8'($urandom), 1'($urandom)));
            end
            hdr = 8'($urandom) | SYNC_MASK;
            if ($urandom_range(0, 7) != 0) hdr = hdr & ~OVERFLOW_MASK;
            stim_q.push_back(beat_of(hdr, $urandom_range(0, 3) == 0));
            stim_q.push_back(beat_of(pick_delta(x_ext, drift), $urandom_range(0, 3) == 0));
            stim_q.push_back(beat_of(pick_delta(y_ext, drift), $urandom_range(0, 3) == 0));
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (track_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                want = track_q.pop_front();
                if (out_beat.packet_done != want.packet_done)
                    report_mismatch("packet_done", out_beat.packet_done, want.packet_done);
                if (out_beat.pos_x != want.pos_x)
                    report_mismatch("pos_x", out_beat.pos_x, want.pos_x);
                if (out_beat.pos_y != want.pos_y)
                    report_mismatch("pos_y", out_beat.pos_y, want.pos_y);
                if (out_beat.button_bits != want.button_bits)
                    report_mismatch("button_bits", out_beat.button_bits, want.button_bits);
                if (out_beat.moved_flag != want.moved_flag)
                    report_mismatch("moved_flag", out_beat.moved_flag, want.moved_flag);
            end
        end
    end

    // The receiver alternates between free flow and random stalls, with one long hold.
    initial begin : out_stall_gen
        int run_left;
        int mode;
        int hold_left;
        run_left  = 0;
        mode      = STALL_FREE;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(STALL_FREE, STALL_HEAVY);
                    run_left = $urandom_range(5, 40);
                end
                run_left--;
                case (mode)
                    STALL_FREE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    default:     out_stall <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("ps2_mouse_packet_tracker_top regression: fail");
        $finish;
    end

    initial begin : main_seq
        int        pw [NUM_PHASES];
        int        ph [NUM_PHASES];
        int        pn [NUM_PHASES];
        int        pd [NUM_PHASES];
        t_in_beat  b;
        t_out_beat want;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        pkt_slot   = SLOT_HEADER;
        pkt_header = '0;
        pkt_dx     = '0;
        cur_x      = RESET_CURSOR_X;
        cur_y      = RESET_CURSOR_Y;
        cur_btn    = '0;
        cur_moved  = 1'b0;
        scr_w      = RESET_WIDTH;
        scr_h      = RESET_HEIGHT;

        pw = '{0, 1, 16383, 8192, 3, 0, 2, 8193};
        ph = '{0, 1, 8192, 16383, 5, 0, 16383, 8193};
        pn = '{45, 45, 270, 45, 45, 60, 45, 45};
        pd = '{2, 2, 7, 6, 2, 3, 4, 2};
        pw[5] = $urandom_range(1, MAX_SCREEN);
        ph[5] = $urandom_range(1, MAX_SCREEN);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            b    = beat_of(directed_rows[i].data, directed_rows[i].clr);
            want = {directed_rows[i].done, directed_rows[i].x, directed_rows[i].y,
                    directed_rows[i].btn, directed_rows[i].mv};
            offer(b, directed_rows[i].typed, want);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_SCREEN_WIDTH, SIZE_W'(pw[p]));
            write_reg(CFG_SCREEN_HEIGHT, SIZE_W'(ph[p]));
            if (p == 0 || p == 6) begin
                write_reg(CFG_SPARE_2, SIZE_W'($urandom));
                write_reg(CFG_SPARE_3, SIZE_W'($urandom));
            end
            cfg_we <= 1'b0;
            build_phase(pn[p], pd[p]);
            if (p == 1) hold_req = 1'b1;
            while (stim_q.size() != 0) offer(stim_q.pop_front(), 1'b0, '0);
            drain();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0) begin
            $display("ps2_mouse_packet_tracker_top regression: pass");
        end else begin
            $display("ps2_mouse_packet_tracker_top regression: fail");
        end
        $finish;
    end

endmodule
